>>> rtl/core/cas_pkg.sv
package cas_pkg;

  // Default size limits of the map
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 3;

  // Configuration registers
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_COLS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BORDER_SIZE = 2'd2;

  localparam int MAP_COLS_W   = 11;
  localparam int MAP_HEIGHT_W = 13;
  localparam int BORDER_W     = 6;

  localparam int MAP_COLS_RST   = 300;
  localparam int MAP_HEIGHT_RST = 300;
  localparam int BORDER_RST     = 5;

  // Result field widths
  localparam int OUT_X_W = 10;
  localparam int OUT_Y_W = 12;

  // Window: three columns of three rows, two history bits per line-store entry
  localparam int WIN_COLS  = 3;
  localparam int COL_BITS  = 3;
  localparam int LS_BITS   = 2;
  localparam int CNT_W     = 4;
  localparam logic [CNT_W-1:0] KEEP_COUNT = 4'd4;

  // Neighbor qualifiers for one window position
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic in_band;
  } nbr_mask_t;

  function automatic int clamp_size(int v, int lo, int hi);
    int r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

>>> rtl/core/cas_if.sv
interface cas_in_if;
  import cas_pkg::*;
  logic valid;
  logic ready;
  logic cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface cas_out_if;
  import cas_pkg::*;
  logic               valid;
  logic               ready;
  logic               new_cell;
  logic [OUT_X_W-1:0] out_x;
  logic [OUT_Y_W-1:0] out_y;
  logic               last_of_frame;

  modport source (output valid, output new_cell, output out_x, output out_y,
                  output last_of_frame, input ready);
  modport sink (input valid, input new_cell, input out_x, input out_y,
                input last_of_frame, output ready);
endinterface

>>> rtl/core/cas_cell.sv
module cas_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic [cas_pkg::COL_BITS-1:0] col_in,
  output logic [cas_pkg::COL_BITS-1:0] col
);
  import cas_pkg::*;

  // Take the neighbor's column on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

endmodule

>>> rtl/core/cas_line_store.sv
module cas_line_store #(
  parameter int DEPTH = cas_pkg::MAX_WIDTH,
  parameter int AW    = $clog2(cas_pkg::MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [cas_pkg::LS_BITS-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [cas_pkg::LS_BITS-1:0] wr_data
);
  import cas_pkg::*;

  logic [LS_BITS-1:0] mem [DEPTH];

  // Write the updated history of one column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/cellular_automaton_smoothing.sv
// Path: the transaction that completes a result's window (the cell row length + 1
//   items later in raster order) passes stage 1, stage 2 and the output register.
// Throughput: one cell per cycle while the result stream does not stall, set by one
//   line store read and one write per item and the three-cell window shifting once per item.
// Reset (synchronous): clears the pipeline, window and raster position and loads
//   width 300, height 300, border 5; the line store is not cleared.
module cellular_automaton_smoothing #(
  parameter int MAX_WIDTH  = cas_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = cas_pkg::MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cas_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cas_pkg::CFG_DATA_W-1:0]  cfg_data,
  cas_in_if.sink                          cell_stream,
  cas_out_if.source                       result_stream
);
  import cas_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int XB = ((WW > BORDER_W) ? WW : BORDER_W) + 1;
  localparam int YB = ((RW > BORDER_W) ? RW : BORDER_W) + 1;

  // Clamped sizes and border
  logic [WW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;
  logic [BORDER_W-1:0] border;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff  <= WW'(clamp_size(MAP_COLS_RST, MIN_SIZE, MAX_WIDTH));
      h_eff  <= HW'(clamp_size(MAP_HEIGHT_RST, MIN_SIZE, MAX_HEIGHT));
      border <= BORDER_W'(BORDER_RST);
    end else if (cfg_we) begin
      if (cfg_index == REG_MAP_COLS) begin
        w_eff <= WW'(clamp_size(int'(cfg_data[MAP_COLS_W-1:0]), MIN_SIZE, MAX_WIDTH));
      end else if (cfg_index == REG_MAP_HEIGHT) begin
        h_eff <= HW'(clamp_size(int'(cfg_data[MAP_HEIGHT_W-1:0]), MIN_SIZE, MAX_HEIGHT));
      end else if (cfg_index == REG_BORDER_SIZE) begin
        border <= cfg_data[BORDER_W-1:0];
      end
    end
  end

  // Pipeline handshake
  logic s1_valid, s2_valid, o_valid;
  logic s2_emit;
  logic accept, s1_adv, s2_adv, s1_free, s2_free, o_free;

  assign o_free   = !o_valid || result_stream.ready;
  assign s2_adv   = s2_valid && (!s2_emit || o_free);
  assign s2_free  = !s2_valid || s2_adv;
  assign s1_adv   = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s1_adv;
  assign accept   = cell_stream.valid && s1_free;
  assign cell_stream.ready = s1_free;

  // Raster position of the incoming item
  logic [XW-1:0] in_column, in_column_next;
  logic [RW-1:0] in_row, in_row_next;
  logic [XW-1:0] pos_c, a_qx;
  logic [RW-1:0] pos_r, h_p1, a_qy;
  logic          a_fin, a_v, a_emit;

  assign h_p1 = RW'(h_eff) + RW'(1);

  always_comb begin
    pos_c = in_column;
    pos_r = in_row;
    if (WW'(in_column) >= w_eff) begin
      pos_c = '0;
      pos_r = in_row + RW'(1);
    end
    if (pos_r > h_p1 || (pos_r == h_p1 && pos_c != '0)) begin
      pos_c = '0;
      pos_r = '0;
    end
    a_fin  = (pos_r == h_p1);
    a_v    = (pos_r < RW'(h_eff)) && cell_stream.cell_value;
    a_emit = (pos_r >= RW'(2)) || (pos_r == RW'(1) && pos_c != '0);
    if (a_fin) begin
      in_column_next = '0;
      in_row_next    = '0;
    end else if (WW'(pos_c) + WW'(1) == w_eff) begin
      in_column_next = '0;
      in_row_next    = pos_r + RW'(1);
    end else begin
      in_column_next = pos_c + XW'(1);
      in_row_next    = pos_r;
    end
    if (pos_c != '0) begin
      a_qx = pos_c - XW'(1);
      a_qy = pos_r - RW'(1);
    end else begin
      a_qx = XW'(w_eff - WW'(1));
      a_qy = pos_r - RW'(2);
    end
  end

  // Advance the raster position per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (accept) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  // Stage 1: line store read in flight
  logic [XW-1:0] s1_c, s1_qx;
  logic [RW-1:0] s1_qy;
  logic          s1_v, s1_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c    <= pos_c;
      s1_v    <= a_v;
      s1_emit <= a_emit;
      s1_qx   <= a_qx;
      s1_qy   <= a_qy;
    end
  end

  logic [LS_BITS-1:0]  ls_rd;
  logic [COL_BITS-1:0] new_col;

  cas_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pos_c),
    .rd_data (ls_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_c),
    .wr_data ({ls_rd[0], s1_v})
  );

  // New column: top row in bit 0, the incoming row in bit 2
  assign new_col = {s1_v, ls_rd[0], ls_rd[1]};

  // Neighbor qualifiers and border band of the emitted position
  nbr_mask_t s1_mask;
  logic      s1_last;

  always_comb begin
    s1_mask.left_ok  = (s1_qx != '0);
    s1_mask.right_ok = (WW'(s1_qx) + WW'(1) < w_eff);
    s1_mask.top_ok   = (s1_qy != '0);
    s1_mask.bot_ok   = (s1_qy + RW'(1) < RW'(h_eff));
    s1_mask.in_band  = (XB'(s1_qx) < XB'(border)) || (YB'(s1_qy) < YB'(border))
                     || (XB'(s1_qx) + XB'(border) > XB'(w_eff))
                     || (YB'(s1_qy) + YB'(border) > YB'(h_eff));
    s1_last = (WW'(s1_qx) == w_eff - WW'(1)) && (s1_qy == RW'(h_eff) - RW'(1));
  end

  // Window: a chain of column cells, newest at index 0
  logic [COL_BITS-1:0] win [WIN_COLS];

  for (genvar i = 0; i < WIN_COLS; i++) begin : g_win
    cas_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_adv),
      .col_in ((i == 0) ? new_col : win[(i == 0) ? 0 : i - 1]),
      .col    (win[i])
    );
  end

  // Stage 2: window holds the item's neighborhood
  logic [XW-1:0] s2_qx;
  logic [RW-1:0] s2_qy;
  logic          s2_last;
  nbr_mask_t     s2_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_emit <= s1_emit;
      s2_qx   <= s1_qx;
      s2_qy   <= s1_qy;
      s2_last <= s1_last;
      s2_mask <= s1_mask;
    end
  end

  // Count set neighbors, clear cells in the border band and apply the 4-5 rule
  logic [COL_BITS-1:0] row_mask;
  logic [COL_BITS-1:0] m_col [WIN_COLS];
  logic [CNT_W-1:0]    count;
  logic                cell_new;

  always_comb begin
    row_mask = {s2_mask.bot_ok, 1'b1, s2_mask.top_ok};
    m_col[0] = win[0] & row_mask & {COL_BITS{s2_mask.right_ok}};
    m_col[1] = win[1] & row_mask & 3'b101;
    m_col[2] = win[2] & row_mask & {COL_BITS{s2_mask.left_ok}};
    count = '0;
    for (int i = 0; i < WIN_COLS; i++) begin
      for (int j = 0; j < COL_BITS; j++) begin
        count = count + CNT_W'(m_col[i][j]);
      end
    end
    if (s2_mask.in_band || count < KEEP_COUNT) begin
      cell_new = 1'b0;
    end else if (count > KEEP_COUNT) begin
      cell_new = 1'b1;
    end else begin
      cell_new = win[1][1];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s2_adv && s2_emit) begin
      o_valid <= 1'b1;
    end else if (result_stream.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_emit) begin
      result_stream.new_cell      <= cell_new;
      result_stream.out_x         <= OUT_X_W'(s2_qx);
      result_stream.out_y         <= OUT_Y_W'(s2_qy);
      result_stream.last_of_frame <= s2_last;
    end
  end

  assign result_stream.valid = o_valid;

endmodule

>>> rtl/core/cas_checker.sv
module cas_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        new_cell,
  input logic [cas_pkg::OUT_X_W-1:0] out_x,
  input logic [cas_pkg::OUT_Y_W-1:0] out_y,
  input logic                        last_of_frame
);
  import cas_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // Reset empties the pipeline, so a cell can enter at once
  a_reset_ready: assert property (@(posedge clk) $past(rst) |-> in_ready)
    else $error("input not ready right after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(new_cell) && $stable(out_x)
      && $stable(out_y) && $stable(last_of_frame))
    else $error("result changed while stalled");

endmodule

bind cellular_automaton_smoothing cas_checker u_cas_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (cell_stream.ready),
  .out_valid     (result_stream.valid),
  .out_ready     (result_stream.ready),
  .new_cell      (result_stream.new_cell),
  .out_x         (result_stream.out_x),
  .out_y         (result_stream.out_y),
  .last_of_frame (result_stream.last_of_frame)
);
